// ===== rtl/pec_pkg.sv =====
// Shared constants, codes and handshake structs for the probe conditioner.
package pec_pkg;

    localparam int RAW_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 16;

    // item modes
    localparam logic [2:0] MODE_SAMPLE = 3'd0;
    localparam logic [2:0] MODE_ZERO   = 3'd1;
    localparam logic [2:0] MODE_LOW    = 3'd2;
    localparam logic [2:0] MODE_HIGH   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // cal_status codes
    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_REJ  = 2'd2;

    typedef struct packed {
        logic start;
        logic long_run;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_rsp;

endpackage

// ===== rtl/probe_ewma_two_point_calibration_top.sv =====
// Two-channel probe conditioner: ADC to volts, EWMA smoothing, two-point calibration.
// One item is taken at a time and gives one result item. A sample item runs two
// bit-serial divisions (ADC count to volts, then the 0.1/0.9 average) and one
// bit-serial multiply for the calibrated reading. A slope item runs one long division of
// FRAC_BITS+7 quotient bits and the multiply. Zero point, clear and rejected items only
// run the multiply. The divider and the multiplier each retire one bit per cycle. A
// finished result waits in the output register while the next item is taken. No
// clearing pass after reset; the configuration port always accepts writes.
module probe_ewma_two_point_calibration_top #(
    parameter int RAW_BITS  = pec_pkg::RAW_BITS_DEF,
    parameter int FRAC_BITS = pec_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((RAW_BITS+7)/8)*8-1:0]             s_axis_tdata,  // raw_sample
    input  logic [3:0]                                s_axis_tuser,  // mode, channel
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((FRAC_BITS+9+7)/8)*8-1:0]          m_axis_tdata,  // reading
    output logic [2:0]                                m_axis_tuser,  // reading_channel, cal_status
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [FRAC_BITS+1:0]                      i_cfg_data     // min_cal_span
);

    localparam int VW     = FRAC_BITS + 2;
    localparam int GW     = FRAC_BITS + 7;
    localparam int OW     = FRAC_BITS + 9;
    localparam int DBW    = FRAC_BITS + 3;
    localparam int QW     = GW;
    localparam int PW     = GW + DBW;
    localparam int SW     = FRAC_BITS + 11;
    localparam int RW     = FRAC_BITS + 12;
    localparam int NINE_W = FRAC_BITS + 6;
    localparam int ODW    = ((OW + 7) / 8) * 8;
    localparam int DW     = (RAW_BITS + 4 > FRAC_BITS + 9) ? RAW_BITS + 4 : FRAC_BITS + 9;
    localparam int NW     = (RAW_BITS + FRAC_BITS + 6 > 2 * FRAC_BITS + 8) ?
                            RAW_BITS + FRAC_BITS + 6 : 2 * FRAC_BITS + 8;

    localparam logic [VW-1:0] PH_B_RST =
        VW'(((64'd165 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [GW-1:0] PH_G_RST =
        GW'(64'd0 - (((64'd57 << FRAC_BITS) + 64'd5) / 64'd10));
    localparam logic [GW-1:0] EC_G_RST =
        GW'(((64'd3 << FRAC_BITS) + 64'd1) / 64'd2);
    localparam logic [VW-1:0] SPAN_RST =
        VW'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [63:0]   VDEN     = 64'd10 * ((64'd1 << RAW_BITS) - 64'd1);
    localparam logic [NW-1:0] VHALF    = NW'(VDEN / 64'd2);
    localparam logic [NW-1:0] CNUM_PH  = NW'(64'd3 << (2 * FRAC_BITS));
    localparam logic [NW-1:0] CNUM_EC  = NW'(64'd141 << (2 * FRAC_BITS));
    localparam logic [QW-1:0] CAP_POS  = QW'((64'd1 << (GW - 1)) - 64'd1);
    localparam logic [QW-1:0] CAP_NEG  = QW'(64'd1 << (GW - 1));
    localparam logic [PW:0]   HALF     = (PW + 1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [RW-1:0] SEVEN_R = RW'(64'd7 << FRAC_BITS);
    localparam logic signed [RW-1:0] OMAX_R  = RW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic signed [RW-1:0] OMIN_R  = ~OMAX_R;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SLDEN  = 9'b000000100,
        S_SLNUM  = 9'b000001000,
        S_DSTART = 9'b000010000,
        S_DWAIT  = 9'b000100000,
        S_EVAL   = 9'b001000000,
        S_MWAIT  = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        JOB_VOLT  = 2'd0,
        JOB_EWMA  = 2'd1,
        JOB_SLOPE = 2'd2
    } t_job;

    t_state r_state, n_state;
    t_job   r_job, n_job;

    logic                r_oval, n_oval;
    logic [VW-1:0]       r_span, n_span;
    logic [VW-1:0]       r_ph_s, n_ph_s, r_ec_s, n_ec_s;
    logic [VW-1:0]       r_ph_b, n_ph_b, r_ec_b, n_ec_b;
    logic [GW-1:0]       r_ph_g, n_ph_g, r_ec_g, n_ec_g;

    logic [2:0]          r_mode, n_mode;
    logic                r_ch, n_ch;
    logic [RAW_BITS-1:0] r_raw, n_raw;
    logic [NW-1:0]       r_num, n_num;
    logic [DW-1:0]       r_den, n_den;
    logic                r_long, n_long;
    logic [NINE_W-1:0]   r_nine, n_nine;
    logic [VW-1:0]       r_mag, n_mag;
    logic                r_dneg, n_dneg;
    logic [1:0]          r_stat, n_stat;
    logic signed [SW-1:0] r_sh, n_sh;
    logic [OW-1:0]       r_odata, n_odata;
    logic [1:0]          r_ostat, n_ostat;
    logic                r_och, n_och;

    logic [VW-1:0]        w_s, w_b;
    logic [GW-1:0]        w_g;
    logic signed [DBW-1:0] w_dif, w_ndif;
    logic [VW-1:0]        w_mag;
    logic                 w_span_ok;
    logic                 w_negres;
    logic [QW-1:0]        w_cap, w_magq, w_gnew;
    logic [PW:0]          w_t;
    logic signed [RW-1:0] w_shx, w_rd;
    logic [OW-1:0]        w_out;
    logic                 w_out_free;

    pec_pkg::t_div_req    w_div_req;
    pec_pkg::t_div_rsp    w_div_rsp;
    logic [QW-1:0]        w_quo;
    logic                 w_mul_done;
    logic signed [PW-1:0] w_prod;

    pec_div #(
        .NW (NW),
        .DW (DW),
        .QW (QW),
        .QS (VW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_rsp   (w_div_rsp),
        .o_quo   (w_quo)
    );

    pec_mul #(
        .AW (GW),
        .BW (DBW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_EVAL),
        .i_a     (w_g),
        .i_b     (w_dif),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_div_req.start    = (r_state == S_DSTART);
    assign w_div_req.long_run = r_long;

    always_comb begin
        w_s       = r_ch ? r_ec_s : r_ph_s;
        w_b       = r_ch ? r_ec_b : r_ph_b;
        w_g       = r_ch ? r_ec_g : r_ph_g;
        w_dif     = $signed({1'b0, w_s}) - $signed({1'b0, w_b});
        w_ndif    = -w_dif;
        w_mag     = w_dif[DBW-1] ? w_ndif[VW-1:0] : w_dif[VW-1:0];
        // EC takes only a high point above its offset
        w_span_ok = (w_mag > r_span) &&
                    (!r_ch || (r_mode == pec_pkg::MODE_HIGH && !w_dif[DBW-1]));

        // slope sign and saturation limit; high point below offset may reach -2^(GW-1)
        w_negres = r_dneg ^ (r_mode == pec_pkg::MODE_LOW);
        w_cap    = (r_mode == pec_pkg::MODE_HIGH && r_dneg) ? CAP_NEG : CAP_POS;
        w_magq   = (w_div_rsp.ovf || w_quo > w_cap) ? w_cap : w_quo;
        w_gnew   = w_negres ? (QW'(0) - w_magq) : w_magq;

        // round half up, then floor shift
        w_t      = {w_prod[PW-1], w_prod} + HALF;

        w_shx    = {{(RW - SW){r_sh[SW-1]}}, r_sh};
        if (r_ch) begin
            w_rd = r_sh[SW-1] ? '0 : w_shx;
        end else begin
            w_rd = w_shx + SEVEN_R;
        end
        if (w_rd > OMAX_R) begin
            w_out = OMAX_R[OW-1:0];
        end else if (w_rd < OMIN_R) begin
            w_out = OMIN_R[OW-1:0];
        end else begin
            w_out = w_rd[OW-1:0];
        end
        w_out_free = !r_oval || m_axis_tready;
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_oval  = r_oval && !m_axis_tready;
        n_span  = i_cfg_valid ? i_cfg_data : r_span;
        n_ph_s  = r_ph_s;
        n_ec_s  = r_ec_s;
        n_ph_b  = r_ph_b;
        n_ec_b  = r_ec_b;
        n_ph_g  = r_ph_g;
        n_ec_g  = r_ec_g;
        n_mode  = r_mode;
        n_ch    = r_ch;
        n_raw   = r_raw;
        n_num   = r_num;
        n_den   = r_den;
        n_long  = r_long;
        n_nine  = r_nine;
        n_mag   = r_mag;
        n_dneg  = r_dneg;
        n_stat  = r_stat;
        n_sh    = r_sh;
        n_odata = r_odata;
        n_ostat = r_ostat;
        n_och   = r_och;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser[2:0];
                    n_ch    = s_axis_tuser[3];
                    n_raw   = s_axis_tdata[RAW_BITS-1:0];
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_stat  = pec_pkg::STAT_REJ;
                n_state = S_EVAL;
                case (r_mode)
                    pec_pkg::MODE_SAMPLE: begin
                        // count*33*2^F/(10*(2^A-1)), rounded
                        n_num   = (((NW'(r_raw) << 5) + NW'(r_raw)) << FRAC_BITS) + VHALF;
                        n_den   = DW'(VDEN);
                        n_long  = 1'b0;
                        n_nine  = (NINE_W'(w_s) << 3) + NINE_W'(w_s);
                        n_job   = JOB_VOLT;
                        n_stat  = pec_pkg::STAT_NONE;
                        n_state = S_DSTART;
                    end
                    pec_pkg::MODE_ZERO: begin
                        if (r_ch) begin
                            n_ec_b = r_ec_s;
                        end else begin
                            n_ph_b = r_ph_s;
                        end
                        n_stat = pec_pkg::STAT_OK;
                    end
                    pec_pkg::MODE_LOW, pec_pkg::MODE_HIGH: begin
                        n_mag  = w_mag;
                        n_dneg = w_dif[DBW-1];
                        if (w_span_ok) begin
                            n_state = S_SLDEN;
                        end
                    end
                    pec_pkg::MODE_CLEAR: begin
                        if (r_ch) begin
                            n_ec_b = '0;
                            n_ec_g = EC_G_RST;
                        end else begin
                            n_ph_b = PH_B_RST;
                            n_ph_g = PH_G_RST;
                        end
                        n_stat = pec_pkg::STAT_OK;
                    end
                    default: begin
                        n_stat = pec_pkg::STAT_REJ;
                    end
                endcase
            end
            S_SLDEN: begin
                // EC divides 1.41 by the span, done as 141/(100*span)
                if (r_ch) begin
                    n_den = (DW'(r_mag) << 6) + (DW'(r_mag) << 5) + (DW'(r_mag) << 2);
                end else begin
                    n_den = DW'(r_mag);
                end
                n_state = S_SLNUM;
            end
            S_SLNUM: begin
                n_num   = (r_ch ? CNUM_EC : CNUM_PH) + NW'(r_den >> 1);
                n_long  = 1'b1;
                n_job   = JOB_SLOPE;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_rsp.done) begin
                    case (r_job)
                        JOB_VOLT: begin
                            n_num   = NW'(w_quo[VW-1:0]) + NW'(r_nine) + NW'(5);
                            n_den   = DW'(10);
                            n_long  = 1'b0;
                            n_job   = JOB_EWMA;
                            n_state = S_DSTART;
                        end
                        JOB_EWMA: begin
                            if (r_ch) begin
                                n_ec_s = w_quo[VW-1:0];
                            end else begin
                                n_ph_s = w_quo[VW-1:0];
                            end
                            n_state = S_EVAL;
                        end
                        JOB_SLOPE: begin
                            if (r_ch) begin
                                n_ec_g = w_gnew;
                            end else begin
                                n_ph_g = w_gnew;
                            end
                            n_stat  = pec_pkg::STAT_OK;
                            n_state = S_EVAL;
                        end
                        default: begin
                            n_state = S_EVAL;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (w_mul_done) begin
                    n_sh    = w_t[PW:FRAC_BITS];
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_oval  = 1'b1;
                    n_odata = w_out;
                    n_ostat = r_stat;
                    n_och   = r_ch;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_span  <= SPAN_RST;
            r_ph_s  <= PH_B_RST;
            r_ec_s  <= '0;
            r_ph_b  <= PH_B_RST;
            r_ec_b  <= '0;
            r_ph_g  <= PH_G_RST;
            r_ec_g  <= EC_G_RST;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_span  <= n_span;
            r_ph_s  <= n_ph_s;
            r_ec_s  <= n_ec_s;
            r_ph_b  <= n_ph_b;
            r_ec_b  <= n_ec_b;
            r_ph_g  <= n_ph_g;
            r_ec_g  <= n_ec_g;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_mode  <= n_mode;
        r_ch    <= n_ch;
        r_raw   <= n_raw;
        r_num   <= n_num;
        r_den   <= n_den;
        r_long  <= n_long;
        r_nine  <= n_nine;
        r_mag   <= n_mag;
        r_dneg  <= n_dneg;
        r_stat  <= n_stat;
        r_sh    <= n_sh;
        r_odata <= n_odata;
        r_ostat <= n_ostat;
        r_och   <= n_och;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = ODW'(r_odata);
    assign m_axis_tuser  = {r_ostat, r_och};
    assign o_cfg_ready   = 1'b1;

endmodule

// ===== rtl/pec_div.sv =====
// Restoring divider, one quotient bit per cycle, short or long quotient length.
module pec_div #(
    parameter int NW = 40,
    parameter int DW = 25,
    parameter int QW = 23,
    parameter int QS = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pec_pkg::t_div_req i_req,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    output pec_pkg::t_div_rsp o_rsp,
    output logic [QW-1:0]     o_quo
);

    localparam int CW = $clog2(QW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [QW-1:0] r_num, n_num;
    logic [QW-1:0] r_quo, n_quo;
    logic [NW-1:0] w_hi;
    logic [DW:0]   w_part;
    logic [DW:0]   w_trial;

    always_comb begin
        // upper numerator part is below the divisor unless the quotient overflows
        w_hi    = i_req.long_run ? (i_num >> QW) : (i_num >> QS);
        w_part  = {r_rem, r_num[QW-1]};
        w_trial = w_part - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_num   = r_num;
        n_quo   = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_ovf  = (w_hi >= NW'(i_den));
            n_rem  = w_hi[DW-1:0];
            n_den  = i_den;
            n_num  = i_req.long_run ? i_num[QW-1:0] : (QW'(i_num[QS-1:0]) << (QW - QS));
            n_quo  = '0;
            n_cnt  = i_req.long_run ? CW'(QW) : CW'(QS);
        end else if (r_busy) begin
            n_rem = w_trial[DW] ? w_part[DW-1:0] : w_trial[DW-1:0];
            n_quo = {r_quo[QW-2:0], ~w_trial[DW]};
            n_num = r_num << 1;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf <= n_ovf;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_num <= n_num;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_quo      = r_quo;

endmodule

// ===== rtl/pec_mul.sv =====
// Signed shift-add multiplier, one multiplier bit per cycle, LSB first.
module pec_mul #(
    parameter int AW = 23,
    parameter int BW = 19
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic                    o_done,
    output logic signed [AW+BW-1:0] o_prod
);

    localparam int CW = $clog2(BW + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [AW-1:0] r_a, n_a;
    logic signed [AW+1:0] r_acc, n_acc;
    logic [BW-1:0]        r_b, n_b;
    logic signed [AW+1:0] w_aext;
    logic signed [AW+1:0] w_add;
    logic signed [AW+1:0] w_sum;

    always_comb begin
        w_aext = {{2{r_a[AW-1]}}, r_a};
        // the sign bit of the multiplier weighs negative
        if (!r_b[0]) begin
            w_add = '0;
        end else if (r_cnt == CW'(1)) begin
            w_add = -w_aext;
        end else begin
            w_add = w_aext;
        end
        w_sum  = r_acc + w_add;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_acc  = r_acc;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(BW);
            n_a    = i_a;
            n_acc  = '0;
            n_b    = i_b;
        end else if (r_busy) begin
            n_acc = w_sum >>> 1;
            n_b   = {w_sum[0], r_b[BW-1:1]};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_acc <= n_acc;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = {r_acc[AW-1:0], r_b};

endmodule

// ===== rtl/pec_chk.sv =====
// Port-level checker for the probe conditioner, bound to the top level.
module pec_chk #(
    parameter int RAW_BITS  = pec_pkg::RAW_BITS_DEF,
    parameter int FRAC_BITS = pec_pkg::FRAC_BITS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [((FRAC_BITS+9+7)/8)*8-1:0] m_axis_tdata,
    input logic [2:0]                       m_axis_tuser
);

    logic [1:0] r_pend, n_pend;

    // items taken but not yet delivered
    always_comb begin
        n_pend = r_pend + 2'(s_axis_tvalid && s_axis_tready)
                        - 2'(m_axis_tvalid && m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_one_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_pend < 2'd2)
        else $error("input taken with two items pending");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != 2'd0)
        else $error("result without a pending item");

    a_ec_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[FRAC_BITS+8])
        else $error("negative conductivity reading");

endmodule

bind probe_ewma_two_point_calibration_top pec_chk #(
    .RAW_BITS  (RAW_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_pec_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-channel probe conditioner (EWMA plus two-point cal).
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ADC       = pec_pkg::RAW_BITS_DEF;
    localparam int     FRAC      = pec_pkg::FRAC_BITS_DEF;
    localparam longint ONE_Q     = longint'(1) << FRAC;
    localparam longint VOLT_MASK = (longint'(1) << (FRAC + 2)) - 1;
    localparam longint GAIN_MAX  = (longint'(1) << (FRAC + 6)) - 1;
    localparam longint GAIN_MIN  = -GAIN_MAX - 1;
    localparam longint OUT_MAX   = (longint'(1) << (FRAC + 8)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;
    localparam int     SPAN_HIGH = 216268;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     RANDOM_ITEMS = 550;

    typedef struct packed {
        logic [FRAC+8:0] reading;
        logic            channel;
        logic [1:0]      status;
    } t_probe_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [((ADC+7)/8)*8-1:0]     s_axis_tdata;   // raw_sample
    logic [3:0]                   s_axis_tuser;   // mode, channel
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [((FRAC+9+7)/8)*8-1:0]  m_axis_tdata;   // reading
    logic [2:0]                   m_axis_tuser;   // reading_channel, cal_status
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [FRAC+1:0]              i_cfg_data;     // min_cal_span

    // predictor state
    longint ph_volts, ec_volts, ph_offset, ec_offset, ph_mult, ec_mult, min_span;

    t_probe_result pending_readings[$];
    int  mismatch_count;
    int  items_sent;
    int  cycle_count;
    bit  tx_gaps_on;
    bit  rx_stalls_on;
    int  rx_stall_left;

    probe_ewma_two_point_calibration_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint qconst(longint num, longint den);
        return ((num << FRAC) + den / 2) / den;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // round to nearest, ties up: same as floor((p + half) / 2^FRAC)
    function automatic longint drop_frac(longint p);
        return (p + (ONE_Q >>> 1)) >>> FRAC;
    endfunction

    function automatic longint calibrated_reading(bit ch);
        longint r;
        if (ch == 1'b0) begin
            r = 7 * ONE_Q + drop_frac((ph_volts - ph_offset) * ph_mult);
        end else begin
            r = drop_frac((ec_volts - ec_offset) * ec_mult);
            if (r < 0) r = 0;
        end
        return clamp(r, OUT_MIN, OUT_MAX);
    endfunction

    function automatic longint slope_gain(longint cnum, longint cden, longint diff);
        longint mag, num, den, q;
        mag = (diff < 0) ? -diff : diff;
        num = cnum << (2 * FRAC);
        den = cden * mag;
        q   = (num + den / 2) / den;
        return clamp((diff < 0) ? -q : q, GAIN_MIN, GAIN_MAX);
    endfunction

    function automatic void reset_predictor();
        min_span  = qconst(5, 100);
        ph_volts  = qconst(165, 100);
        ec_volts  = 0;
        ph_offset = qconst(165, 100);
        ph_mult   = -qconst(57, 10);
        ec_offset = 0;
        ec_mult   = qconst(3, 2);
    endfunction

    function automatic void predict_probe_item(logic [2:0] mode, bit ch, logic [ADC-1:0] raw);
        longint den, v, diff, mag, m;
        logic [1:0] status;
        t_probe_result res;
        status = pec_pkg::STAT_REJ;
        if (mode == pec_pkg::MODE_SAMPLE) begin
            den = 10 * ((longint'(1) << ADC) - 1);
            v = ((longint'(raw) * 33 << FRAC) + den / 2) / den;
            if (ch) ec_volts = ((v + 9 * ec_volts + 5) / 10) & VOLT_MASK;
            else    ph_volts = ((v + 9 * ph_volts + 5) / 10) & VOLT_MASK;
            status = pec_pkg::STAT_NONE;
        end else if (mode == pec_pkg::MODE_ZERO) begin
            if (ch) ec_offset = ec_volts;
            else    ph_offset = ph_volts;
            status = pec_pkg::STAT_OK;
        end else if (mode == pec_pkg::MODE_LOW || mode == pec_pkg::MODE_HIGH) begin
            if (ch == 1'b0) begin
                diff = ph_volts - ph_offset;
                mag  = (diff < 0) ? -diff : diff;
                if (mag > min_span) begin
                    m = slope_gain(3, 1, diff);
                    ph_mult = (mode == pec_pkg::MODE_LOW) ? clamp(-m, GAIN_MIN, GAIN_MAX) : m;
                    status = pec_pkg::STAT_OK;
                end
            end else if (mode == pec_pkg::MODE_HIGH) begin
                diff = ec_volts - ec_offset;
                if (diff > 0 && diff > min_span) begin
                    ec_mult = slope_gain(141, 100, diff);
                    status = pec_pkg::STAT_OK;
                end
            end
        end else if (mode == pec_pkg::MODE_CLEAR) begin
            if (ch) begin
                ec_offset = 0;
                ec_mult   = qconst(3, 2);
            end else begin
                ph_offset = qconst(165, 100);
                ph_mult   = -qconst(57, 10);
            end
            status = pec_pkg::STAT_OK;
        end
        res.reading = (FRAC+9)'(calibrated_reading(ch));
        res.channel = ch;
        res.status  = status;
        pending_readings.push_back(res);
    endfunction

    // ---------------- idling ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (!rx_stalls_on) begin
            m_axis_tready = 1'b1;
        end else if (rx_stall_left != 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left--;
        end else begin
            rx_stall_left = pick_gap();
            m_axis_tready = (rx_stall_left == 0);
            if (rx_stall_left != 0) rx_stall_left--;
        end
    end

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint exp_val, longint act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                     what, exp_val, act_val, cycle_count);
    endtask

    always @(posedge i_clk) begin
        t_probe_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected result item, reading", 0,
                                $signed(m_axis_tdata[FRAC+8:0]));
            end else begin
                exp_res = pending_readings.pop_front();
                if (m_axis_tdata[FRAC+8:0] !== exp_res.reading)
                    report_mismatch("reading", $signed(exp_res.reading),
                                    $signed(m_axis_tdata[FRAC+8:0]));
                if (m_axis_tuser[0] !== exp_res.channel)
                    report_mismatch("reading_channel", exp_res.channel, m_axis_tuser[0]);
                if (m_axis_tuser[2:1] !== exp_res.status)
                    report_mismatch("cal_status", exp_res.status, m_axis_tuser[2:1]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_readings.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    // entered and left at a falling edge
    task automatic send_item(logic [2:0] mode, bit ch, logic [ADC-1:0] raw);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        repeat (gap) @(negedge i_clk);
        s_axis_tdata  = (((ADC+7)/8)*8)'(raw);
        s_axis_tuser  = {ch, mode};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_probe_item(mode, ch, raw);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_results_done();
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_min_span(logic [FRAC+1:0] span);
        wait_results_done();
        i_cfg_data  = span;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        min_span = span;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [ADC-1:0] near_level(int lvl);
        int v;
        v = lvl + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > (1 << ADC) - 1) v = (1 << ADC) - 1;
        return v[ADC-1:0];
    endfunction

    // samples at one level, zero point, samples at another level, slope point, then random samples and maybe a clear
    task automatic run_cal_sequence(bit ch);
        int lvl;
        lvl = $urandom_range(0, (1 << ADC) - 1);
        repeat ($urandom_range(3, 12)) send_item(pec_pkg::MODE_SAMPLE, ch, near_level(lvl));
        send_item(pec_pkg::MODE_ZERO, ch, ADC'($urandom));
        lvl = $urandom_range(0, (1 << ADC) - 1);
        repeat ($urandom_range(1, 12)) send_item(pec_pkg::MODE_SAMPLE, ch, near_level(lvl));
        if (ch == 1'b0)
            send_item($urandom_range(0, 1) ? pec_pkg::MODE_LOW : pec_pkg::MODE_HIGH, ch,
                      ADC'($urandom));
        else
            send_item(($urandom_range(0, 7) == 0) ? pec_pkg::MODE_LOW : pec_pkg::MODE_HIGH, ch,
                      ADC'($urandom));
        repeat ($urandom_range(0, 4)) send_item(pec_pkg::MODE_SAMPLE, ch, ADC'($urandom));
        if ($urandom_range(0, 5) == 0) send_item(pec_pkg::MODE_CLEAR, ch, ADC'($urandom));
    endtask

    // ---------------- tests ----------------
    task automatic test_sample_extremes();
        send_item(pec_pkg::MODE_SAMPLE, 1'b0, '1);
        send_item(pec_pkg::MODE_SAMPLE, 1'b0, '0);
        send_item(pec_pkg::MODE_SAMPLE, 1'b1, '1);
        send_item(pec_pkg::MODE_SAMPLE, 1'b1, '0);
    endtask

    task automatic test_ignored_modes();
        send_item(3'd5, 1'b0, 12'hAAA);
        send_item(3'd6, 1'b1, 12'h555);
        send_item(3'd7, 1'b0, '1);
        send_item(3'd7, 1'b1, '0);
    endtask

    task automatic test_calibration_points();
        send_item(pec_pkg::MODE_ZERO, 1'b0, '0);
        send_item(pec_pkg::MODE_SAMPLE, 1'b0, '1);
        send_item(pec_pkg::MODE_SAMPLE, 1'b0, '1);
        send_item(pec_pkg::MODE_HIGH, 1'b0, '0);
        send_item(pec_pkg::MODE_LOW, 1'b0, '0);
        send_item(pec_pkg::MODE_LOW, 1'b1, '0);      // unsupported on conductivity
        send_item(pec_pkg::MODE_ZERO, 1'b1, '0);
        send_item(pec_pkg::MODE_SAMPLE, 1'b1, '1);
        send_item(pec_pkg::MODE_HIGH, 1'b1, '0);
        send_item(pec_pkg::MODE_ZERO, 1'b1, '0);
        send_item(pec_pkg::MODE_HIGH, 1'b1, '0);     // no span left
        send_item(pec_pkg::MODE_CLEAR, 1'b0, '0);
        send_item(pec_pkg::MODE_CLEAR, 1'b1, '0);
    endtask

    // zero span: a sample close to the zero point level saturates the gain; EC below its offset clamps to zero
    task automatic test_saturation_and_clamp();
        write_min_span('0);
        send_item(pec_pkg::MODE_ZERO, 1'b0, '0);
        send_item(pec_pkg::MODE_SAMPLE, 1'b0, 12'd2100);
        send_item(pec_pkg::MODE_HIGH, 1'b0, '0);
        send_item(pec_pkg::MODE_SAMPLE, 1'b0, '1);
        send_item(pec_pkg::MODE_ZERO, 1'b1, '0);
        send_item(pec_pkg::MODE_SAMPLE, 1'b1, '0);
    endtask

    task automatic test_random_phase(logic [FRAC+1:0] span, int n_items);
        int stop_at;
        write_min_span(span);
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7)
                run_cal_sequence($urandom_range(0, 1));
            else
                send_item(3'($urandom), 1'($urandom), ADC'($urandom));
        end
    endtask

    task automatic test_random_stream();
        int start;
        start = items_sent;
        test_random_phase('0, 90);
        test_random_phase((FRAC+2)'(SPAN_HIGH), 80);
        test_random_phase(18'h1FFFF, 80);
        test_random_phase((FRAC+2)'(qconst(5, 100)), 90);
        while (items_sent - start < RANDOM_ITEMS)
            test_random_phase((FRAC+2)'($urandom_range(0, 8000)), 70);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        rx_stall_left = 0;
        mismatch_count = 0;
        items_sent    = 0;
        cycle_count   = 0;
        reset_predictor();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sample_extremes();
        test_ignored_modes();
        test_calibration_points();
        test_saturation_and_clamp();
        test_random_stream();

        wait_results_done();
        repeat (80) @(negedge i_clk);
        if (pending_readings.size() != 0)
            report_mismatch("results left over", 0, pending_readings.size());
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pec_pkg.sv
rtl/pec_div.sv
rtl/pec_mul.sv
rtl/probe_ewma_two_point_calibration_top.sv
rtl/pec_chk.sv
tb/testbench.sv
